[rtl/cprd_pkg.sv]
`timescale 1ns / 1ps

package cprd_pkg;

  localparam int RUN_MAX_DEF = 65535;
  localparam int DIM_MAX_DEF = 4095;

  // result kinds
  localparam logic [1:0] KIND_RUN = 2'd0;
  localparam logic [1:0] KIND_ROW = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // character classes
  localparam logic [2:0] CLS_END    = 3'd0;
  localparam logic [2:0] CLS_DIGIT  = 3'd1;
  localparam logic [2:0] CLS_ROW    = 3'd2;
  localparam logic [2:0] CLS_PREFIX = 3'd3;
  localparam logic [2:0] CLS_RUN    = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_Y      = 8'h79;

  localparam logic [7:0] LEVEL_FULL  = 8'd255;
  localparam logic [4:0] PREFIX_STEP = 5'd24;
  localparam int         PREFIX_BASE = 25;
  // a lettered level is prefix*24 + c - ('A' - 25)
  localparam logic [8:0] LETTER_OFS  = 9'(int'(CH_A) - PREFIX_BASE);

  typedef struct packed {
    logic [2:0] cls;
    logic [3:0] digit;
    logic [3:0] prefix;
    logic [7:0] level;         // level of a plain cell symbol
    logic [7:0] letter_level;  // level when a prefix is pending
  } cprd_class_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  cell_level;
    logic [15:0] run_length;
    logic [11:0] pattern_width;
    logic [11:0] pattern_height;
    logic        size_overflow;
  } cprd_result_t;

endpackage

[rtl/cprd_if.sv]
`timescale 1ns / 1ps

interface cprd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_pattern;

  modport source (output valid, output char_code, output start_pattern, input ready);
  modport sink (input valid, input char_code, input start_pattern, output ready);
endinterface

interface cprd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [7:0]  cell_level;
  logic [15:0] run_length;
  logic [11:0] pattern_width;
  logic [11:0] pattern_height;
  logic        size_overflow;

  modport source (output valid, output item_kind, output cell_level, output run_length,
                  output pattern_width, output pattern_height, output size_overflow,
                  input ready);
  modport sink (input valid, input item_kind, input cell_level, input run_length,
                input pattern_width, input pattern_height, input size_overflow,
                output ready);
endinterface

[rtl/cprd_classify.sv]
`timescale 1ns / 1ps

module cprd_classify import cprd_pkg::*; (
  input  logic [7:0]  char_code,
  input  logic [3:0]  prefix_letter,
  output cprd_class_t cls
);

  logic [8:0] letter_sum;
  logic [8:0] letter_ofs;

  assign letter_sum = (9'(prefix_letter) * 9'(PREFIX_STEP)) + 9'(char_code);
  assign letter_ofs = letter_sum - LETTER_OFS;

  always_comb begin
    cls        = '0;
    cls.digit  = 4'(char_code - CH_ZERO);
    cls.prefix = 4'(char_code - CH_P);

    if (char_code == CH_NUL || char_code == CH_BANG) begin
      cls.cls = CLS_END;
    end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      cls.cls = CLS_DIGIT;
    end else if (char_code == CH_DOLLAR) begin
      cls.cls = CLS_ROW;
    end else if (char_code >= CH_P && char_code <= CH_Y) begin
      cls.cls = CLS_PREFIX;
    end else begin
      cls.cls = CLS_RUN;
    end

    // '.', 'b' and anything unknown stay at level 0
    if (char_code == CH_O) begin
      cls.level = LEVEL_FULL;
    end else if (char_code >= CH_A && char_code <= CH_X) begin
      cls.level = 8'(char_code - CH_A) + 8'd1;
    end

    if (letter_sum < LETTER_OFS) begin
      cls.letter_level = 8'd0;
    end else if (letter_ofs > 9'(LEVEL_FULL)) begin
      cls.letter_level = LEVEL_FULL;
    end else begin
      cls.letter_level = letter_ofs[7:0];
    end
  end

endmodule

[rtl/cprd_core.sv]
`timescale 1ns / 1ps

module cprd_core import cprd_pkg::*; #(
  parameter int RUN_MAX = RUN_MAX_DEF,
  parameter int DIM_MAX = DIM_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   char_code,
  input  logic         start_pattern,
  output logic         res_valid,
  output cprd_result_t res,
  output logic         done
);

  localparam int RUN_W = $clog2(RUN_MAX + 1);
  localparam int DIM_W = $clog2(DIM_MAX + 1);
  localparam int SUM_W = ((RUN_W > DIM_W) ? RUN_W : DIM_W) + 1;
  localparam int MUL_W = RUN_W + 4;

  logic [RUN_W-1:0] rc_r, rc_nxt;
  logic [3:0]       pl_r, pl_nxt;
  logic             pp_r, pp_nxt;
  logic [DIM_W-1:0] rl_r, rl_nxt;
  logic [DIM_W-1:0] wr_r, wr_nxt;
  logic [DIM_W-1:0] rs_r, rs_nxt;
  logic             done_r, done_nxt;
  logic             ovf_r, ovf_nxt;

  // state as seen by this item, after an optional pattern restart
  logic [RUN_W-1:0] eff_rc;
  logic [3:0]       eff_pl;
  logic             eff_pp;
  logic [DIM_W-1:0] eff_rl;
  logic [DIM_W-1:0] eff_wr;
  logic [DIM_W-1:0] eff_rs;
  logic             eff_done;
  logic             eff_ovf;

  cprd_class_t      cls;
  logic [RUN_W-1:0] n;
  logic [MUL_W-1:0] mul;
  logic [SUM_W-1:0] row_sum;
  logic [SUM_W-1:0] rows_sum;
  logic             row_sat;
  logic             rows_sat;
  logic [DIM_W-1:0] row_new;
  logic [DIM_W-1:0] rows_new;
  logic [DIM_W-1:0] wide_new;
  logic [RUN_W+15:0] n_ext;
  logic [DIM_W+11:0] wide_ext;
  logic [DIM_W+11:0] rows_ext;

  assign eff_rc   = start_pattern ? '0 : rc_r;
  assign eff_pl   = start_pattern ? '0 : pl_r;
  assign eff_pp   = start_pattern ? 1'b0 : pp_r;
  assign eff_rl   = start_pattern ? '0 : rl_r;
  assign eff_wr   = start_pattern ? '0 : wr_r;
  assign eff_rs   = start_pattern ? DIM_W'(1) : rs_r;
  assign eff_done = start_pattern ? 1'b0 : done_r;
  assign eff_ovf  = start_pattern ? 1'b0 : ovf_r;

  cprd_classify u_classify (
    .char_code     (char_code),
    .prefix_letter (eff_pl),
    .cls           (cls)
  );

  // an absent or zero count means one
  assign n = (eff_rc == '0) ? RUN_W'(1) : eff_rc;

  assign mul = MUL_W'({eff_rc, 3'b000}) + MUL_W'({eff_rc, 1'b0}) + MUL_W'(cls.digit);

  assign row_sum  = SUM_W'(eff_rl) + SUM_W'(n);
  assign rows_sum = SUM_W'(eff_rs) + SUM_W'(n);
  assign row_sat  = row_sum > SUM_W'(DIM_MAX);
  assign rows_sat = rows_sum > SUM_W'(DIM_MAX);
  assign row_new  = row_sat ? DIM_W'(DIM_MAX) : row_sum[DIM_W-1:0];
  assign rows_new = rows_sat ? DIM_W'(DIM_MAX) : rows_sum[DIM_W-1:0];
  assign wide_new = (eff_rl > eff_wr) ? eff_rl : eff_wr;

  assign n_ext    = {16'b0, n};
  assign wide_ext = {12'b0, wide_new};
  assign rows_ext = {12'b0, eff_rs};

  always_comb begin
    rc_nxt    = eff_rc;
    pl_nxt    = eff_pl;
    pp_nxt    = eff_pp;
    rl_nxt    = eff_rl;
    wr_nxt    = eff_wr;
    rs_nxt    = eff_rs;
    done_nxt  = eff_done;
    ovf_nxt   = eff_ovf;
    res_valid = 1'b0;
    res       = '0;

    if (!eff_done) begin
      if (cls.cls == CLS_END) begin
        wr_nxt             = wide_new;
        rc_nxt             = '0;
        pp_nxt             = 1'b0;
        done_nxt           = 1'b1;
        res_valid          = 1'b1;
        res.item_kind      = KIND_END;
        res.pattern_width  = wide_ext[11:0];
        res.pattern_height = rows_ext[11:0];
      end else if (eff_pp || cls.cls == CLS_RUN) begin
        // a pending prefix takes any character but an end mark, digits too, as its letter
        pp_nxt         = 1'b0;
        rc_nxt         = '0;
        rl_nxt         = row_new;
        ovf_nxt        = eff_ovf | row_sat;
        res_valid      = 1'b1;
        res.item_kind  = KIND_RUN;
        res.cell_level = eff_pp ? cls.letter_level : cls.level;
        res.run_length = n_ext[15:0];
      end else if (cls.cls == CLS_DIGIT) begin
        if (mul > MUL_W'(RUN_MAX)) begin
          rc_nxt  = RUN_W'(RUN_MAX);
          ovf_nxt = 1'b1;
        end else begin
          rc_nxt = mul[RUN_W-1:0];
        end
      end else if (cls.cls == CLS_ROW) begin
        rc_nxt         = '0;
        wr_nxt         = wide_new;
        rl_nxt         = '0;
        rs_nxt         = rows_new;
        ovf_nxt        = eff_ovf | rows_sat;
        res_valid      = 1'b1;
        res.item_kind  = KIND_ROW;
        res.run_length = n_ext[15:0];
      end else begin
        pl_nxt = cls.prefix;
        pp_nxt = 1'b1;
      end
    end
    res.size_overflow = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r   <= '0;
      pl_r   <= '0;
      pp_r   <= 1'b0;
      rl_r   <= '0;
      wr_r   <= '0;
      rs_r   <= DIM_W'(1);
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else if (step) begin
      rc_r   <= rc_nxt;
      pl_r   <= pl_nxt;
      pp_r   <= pp_nxt;
      rl_r   <= rl_nxt;
      wr_r   <= wr_nxt;
      rs_r   <= rs_nxt;
      done_r <= done_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign done = done_r;

endmodule

[rtl/cell_pattern_rle_decoder.sv]
`timescale 1ns / 1ps
// Run-length pattern decoder for multistate cell patterns.
// in_ch carries one pattern character per item (char_code) plus start_pattern,
// which restarts the parser before that character is taken. out_ch carries
// cell runs, row ends and the pattern end with the widest row and row count.
// Digits and prefix letters update the parser and give no item.
// Both channels use valid/ready; an item moves when both are high.
// An accepted character lands in an input register, is decoded combinationally
// against the parser state and its item goes to the output register, from which
// out_ch takes it; a stalled output holds the character in the input register.
// One character per cycle is taken while out_ch keeps up; the parser state
// loop (count, row length, row count) is updated by each decoded character.
// When the receiver stalls, the held item stays on out_ch and the input
// register keeps the next character; in_ch.ready drops until out_ch moves.
// After '!' or NUL, characters are swallowed until start_pattern is set.
// Synchronous reset empties both registers and puts the parser at the start
// of a pattern with one row counted.
module cell_pattern_rle_decoder import cprd_pkg::*; #(
  parameter int RUN_MAX = RUN_MAX_DEF,
  parameter int DIM_MAX = DIM_MAX_DEF
) (
  input logic        clk,
  input logic        rst_n,
  cprd_in_if.sink    in_ch,
  cprd_out_if.source out_ch
);

  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_char_r;
  logic         s1_start_r;
  logic         out_valid_r, out_valid_nxt;
  cprd_result_t out_r;
  logic         out_free;
  logic         step;
  logic         in_fire;
  logic         res_valid;
  cprd_result_t res;
  logic         done;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  cprd_core #(
    .RUN_MAX (RUN_MAX),
    .DIM_MAX (DIM_MAX)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .char_code     (s1_char_r),
    .start_pattern (s1_start_r),
    .res_valid     (res_valid),
    .res           (res),
    .done          (done)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (step && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r  <= in_ch.char_code;
      s1_start_r <= in_ch.start_pattern;
    end
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.item_kind      = out_r.item_kind;
  assign out_ch.cell_level     = out_r.cell_level;
  assign out_ch.run_length     = out_r.run_length;
  assign out_ch.pattern_width  = out_r.pattern_width;
  assign out_ch.pattern_height = out_r.pattern_height;
  assign out_ch.size_overflow  = out_r.size_overflow;

  // input side only waits on a full output register that is not being drained
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked output");

  // pattern end leaves the parser closed
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid && res.item_kind == KIND_END) |=> done)
    else $error("parser not closed after pattern end");

  // pattern end and row end carry no cell level
  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.item_kind == KIND_END || out_ch.item_kind == KIND_ROW))
      |-> (out_ch.cell_level == 8'd0))
    else $error("level set on row end or pattern end");

  // a closed parser turns a character without restart into no item
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step && done && !s1_start_r) |-> !res_valid)
    else $error("item produced after pattern end");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench import cprd_pkg::*; ();

  localparam int RUN_LIM      = RUN_MAX_DEF;
  localparam int DIM_LIM      = DIM_MAX_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int STALL_CYCLES = 300;
  localparam int TAIL_CYCLES  = 12;

  localparam logic [7:0] CH_LOW_B = "b";
  localparam logic [7:0] CH_DOT   = ".";

  typedef struct packed {
    logic [7:0] ch;
    logic       start;
  } char_item_t;

  logic clk = 1'b0;
  logic rst_n;

  cprd_in_if  in_ch();
  cprd_out_if out_ch();

  cell_pattern_rle_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // parser copy
  int unsigned  rep_count;
  logic [3:0]   pfx_idx;
  bit           pfx_on;
  int unsigned  row_len;
  int unsigned  widest;
  int unsigned  row_total;
  bit           pat_done;
  bit           size_ovf;

  char_item_t   char_q[$];
  cprd_result_t result_q[$];

  bit  next_start;
  bit  in_fire;
  bit  stall_req;
  bit  stall_on;
  int  send_idle;
  int  recv_idle;
  int  cycles;
  int  chars_used;
  int  results_seen;
  int  ends_seen;
  int  ovf_results;
  int  errors;

  function automatic void clear_parser();
    rep_count = 0;
    pfx_idx   = '0;
    pfx_on    = 1'b0;
    row_len   = 0;
    widest    = 0;
    row_total = 1;
    pat_done  = 1'b0;
    size_ovf  = 1'b0;
  endfunction

  function automatic int unsigned dim_add(int unsigned a, int unsigned b);
    if (a + b > DIM_LIM) begin
      size_ovf = 1'b1;
      return DIM_LIM;
    end
    return a + b;
  endfunction

  function automatic int unsigned take_repeat();
    int unsigned n;
    n = (rep_count != 0) ? rep_count : 1;
    rep_count = 0;
    return n;
  endfunction

  function automatic cprd_result_t cell_run(logic [7:0] lvl);
    cprd_result_t r;
    int unsigned n;
    n = take_repeat();
    row_len = dim_add(row_len, n);
    r = '0;
    r.item_kind     = KIND_RUN;
    r.cell_level    = lvl;
    r.run_length    = 16'(n);
    r.size_overflow = size_ovf;
    return r;
  endfunction

  // Advances the parser copy by one character; returns 1 when it yields a result.
  function automatic bit decode_char(input logic [7:0] c, input logic st,
                                     output cprd_result_t r);
    int lv;
    int unsigned n;
    r = '0;
    if (st)
      clear_parser();
    if (pat_done)
      return 1'b0;
    chars_used++;
    if (c == CH_BANG || c == CH_NUL) begin
      if (row_len > widest)
        widest = row_len;
      rep_count = 0;
      pfx_on    = 1'b0;
      pat_done  = 1'b1;
      r.item_kind      = KIND_END;
      r.pattern_width  = 12'(widest);
      r.pattern_height = 12'(row_total);
      r.size_overflow  = size_ovf;
      return 1'b1;
    end
    if (pfx_on) begin
      // any character is the letter here, clamped into the level range
      lv = int'(pfx_idx) * 24 + 25 + (int'(c) - int'(CH_A));
      if (lv < 0)
        lv = 0;
      if (lv > 255)
        lv = 255;
      pfx_on = 1'b0;
      r = cell_run(8'(lv));
      return 1'b1;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      n = rep_count * 10 + int'(c - CH_ZERO);
      if (n > RUN_LIM) begin
        n = RUN_LIM;
        size_ovf = 1'b1;
      end
      rep_count = n;
      return 1'b0;
    end
    if (c == CH_DOLLAR) begin
      n = take_repeat();
      if (row_len > widest)
        widest = row_len;
      row_len   = 0;
      row_total = dim_add(row_total, n);
      r.item_kind     = KIND_ROW;
      r.run_length    = 16'(n);
      r.size_overflow = size_ovf;
      return 1'b1;
    end
    if (c >= CH_P && c <= CH_Y) begin
      pfx_idx = 4'(c - CH_P);
      pfx_on  = 1'b1;
      return 1'b0;
    end
    if (c == CH_O)
      r = cell_run(LEVEL_FULL);
    else if (c >= CH_A && c <= CH_X)
      r = cell_run(8'(c - CH_A + 8'd1));
    else
      r = cell_run(8'd0);
    return 1'b1;
  endfunction

  task automatic check_field(string nm, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
    end
  endtask

  // input acceptance and result checking
  always @(posedge clk) begin : monitor
    cprd_result_t got;
    cprd_result_t want;
    cprd_result_t pred;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      clear_parser();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.item_kind      = out_ch.item_kind;
        got.cell_level     = out_ch.cell_level;
        got.run_length     = out_ch.run_length;
        got.pattern_width  = out_ch.pattern_width;
        got.pattern_height = out_ch.pattern_height;
        got.size_overflow  = out_ch.size_overflow;
        results_seen++;
        if (got.item_kind == KIND_END)
          ends_seen++;
        if (got.size_overflow)
          ovf_results++;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
        end else begin
          want = result_q.pop_front();
          check_field("item_kind", want.item_kind, got.item_kind);
          check_field("cell_level", want.cell_level, got.cell_level);
          check_field("run_length", want.run_length, got.run_length);
          check_field("pattern_width", want.pattern_width, got.pattern_width);
          check_field("pattern_height", want.pattern_height, got.pattern_height);
          check_field("size_overflow", want.size_overflow, got.size_overflow);
        end
      end
      if (in_fire && decode_char(in_ch.char_code, in_ch.start_pattern, pred))
        result_q.push_back(pred);
    end
  end

  always @(negedge clk) begin : char_driver
    char_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (char_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        it = char_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.char_code     <= it.ch;
        in_ch.start_pattern <= it.start;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_sink
    out_ch.ready <= rst_n && !stall_on && ($urandom_range(99) >= recv_idle);
  end

  // long receiver hold-off while the sender keeps offering
  initial begin : stall_gen
    stall_on = 1'b0;
    wait (stall_req);
    stall_on = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    stall_on = 1'b0;
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycles, result_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_char(logic [7:0] c);
    char_item_t it;
    it.ch    = c;
    it.start = next_start;
    char_q.push_back(it);
    next_start = 1'b0;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i]);
  endtask

  task automatic queue_count();
    int k;
    int unsigned n;
    k = $urandom_range(99);
    if (k < 6)
      n = $urandom_range(4000, 99999);
    else if (k < 12)
      n = 0;
    else
      n = $urandom_range(1, 30);
    push_text($sformatf("%0d", n));
  endtask

  task automatic queue_symbol();
    case ($urandom_range(11))
      0: push_char(CH_LOW_B);
      1: push_char(CH_DOT);
      2, 3: push_char(CH_O);
      4, 5: push_char(CH_A + 8'($urandom_range(23)));
      6, 7, 8: begin
        push_char(CH_P + 8'($urandom_range(9)));
        if ($urandom_range(3) == 0)
          push_char(8'($urandom_range(255)));
        else
          push_char(CH_A + 8'($urandom_range(25)));
      end
      default: push_char(8'($urandom_range(1, 255)));
    endcase
  endtask

  // mostly well-formed patterns, some noise and unterminated ones
  task automatic queue_random();
    int rows_n;
    int cells_n;
    int k;
    if ($urandom_range(99) < 15) begin
      cells_n = $urandom_range(1, 8);
      for (int i = 0; i < cells_n; i++) begin
        next_start = ($urandom_range(3) == 0);
        push_char(8'($urandom_range(255)));
      end
      return;
    end
    next_start = 1'b1;
    rows_n = $urandom_range(1, 4);
    for (int r = 0; r < rows_n; r++) begin
      cells_n = $urandom_range(1, 5);
      for (int i = 0; i < cells_n; i++) begin
        if ($urandom_range(1) == 0)
          queue_count();
        queue_symbol();
      end
      if (r < rows_n - 1) begin
        if ($urandom_range(2) == 0)
          queue_count();
        push_char(CH_DOLLAR);
      end
    end
    k = $urandom_range(19);
    if (k < 16)
      push_char(CH_BANG);
    else if (k < 18)
      push_char(CH_NUL);
  endtask

  task automatic queue_directed();
    // levels: full, empty, plain letters, prefixed letters (one clamped high) and prefixed non-letters
    next_start = 1'b1;
    push_text("3obAXpAyXp0r$2$!");
    push_char(CH_O);  // swallowed after the end
    // count saturation, wide row, tall row count, prefix dropped at end
    next_start = 1'b1;
    push_text("99999o8000$q!");
    // pending count dropped at NUL end
    next_start = 1'b1;
    push_char("5");
    push_char(CH_NUL);
  endtask

  task automatic run_phase(int s_idle, int r_idle, int target);
    send_idle = s_idle;
    recv_idle = r_idle;
    while (chars_used < target) begin
      if (char_q.size() < 16)
        queue_random();
      else
        @(posedge clk);
    end
    while (char_q.size() != 0 || in_ch.valid)
      @(posedge clk);
  endtask

  initial begin : stimulus
    rst_n               = 1'b0;
    stall_req           = 1'b0;
    next_start          = 1'b0;
    send_idle           = 20;
    recv_idle           = 72;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_directed();
    run_phase(20, 72, 190);
    run_phase(72, 20, 360);
    stall_req = 1'b1;
    run_phase(0, 0, 500);

    while (result_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Decoded %0d pattern characters into %0d checked results", chars_used,
             results_seen);
    $display("  %0d pattern ends, %0d results flagged size overflow, %0d mismatches",
             ends_seen, ovf_results, errors);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
rtl/cprd_pkg.sv
rtl/cprd_if.sv
rtl/cprd_classify.sv
rtl/cprd_core.sv
rtl/cell_pattern_rle_decoder.sv
verif/testbench.sv
